// ===== rtl/audio_sample_fifo_dither_pwm_unit_macros.svh =====
// Assertion helpers used by the checker module asfdp_chk.
`ifndef AUDIO_SAMPLE_FIFO_DITHER_PWM_UNIT_MACROS_SVH
`define AUDIO_SAMPLE_FIFO_DITHER_PWM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASFDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASFDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/asfdp_pkg.sv =====
package asfdp_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LEVEL_W  = 12;
	localparam int unsigned ROOM_W   = 12;

	localparam logic [0:0] KIND_PUSH = 1'b0;
	localparam logic [0:0] KIND_TICK = 1'b1;

	// LCG step, and the same step applied twice folded into one multiply-add
	localparam logic [31:0] LCG_MUL  = 32'd1103515245;
	localparam logic [31:0] LCG_ADD  = 32'd12345;
	localparam logic [31:0] LCG_MUL2 = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
	localparam logic [31:0] LCG_ADD2 = 32'(64'(LCG_ADD) * 64'(LCG_MUL) + 64'(LCG_ADD));

	localparam int unsigned DITHER_LSB = 20;
	localparam int unsigned DITHER_W   = 5;
	localparam logic [16:0] LEVEL_BIAS = 17'd31;
	localparam logic [12:0] LEVEL_CAP  = 13'd4096;

	typedef struct packed {
		logic push;    // push request taken this cycle
		logic tick;    // tick request taken this cycle
		logic finish;  // tick result goes to the output register
	} asfdp_cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being drained
	} asfdp_stat_t;

endpackage

// ===== rtl/asfdp_in_if.sv =====
interface asfdp_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] sample;
	logic               batch_last;

	modport source (output valid, output kind, output sample, output batch_last, input ready);
	modport sink   (input valid, input kind, input sample, input batch_last, output ready);
endinterface

// ===== rtl/asfdp_out_if.sv =====
interface asfdp_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] level;
	logic        level_valid;
	logic        underrun;
	logic        accepted;
	logic [11:0] room;

	modport source (output valid, output level, output level_valid, output underrun,
		output accepted, output room, input ready);
	modport sink   (input valid, input level, input level_valid, input underrun,
		input accepted, input room, output ready);
endinterface

// ===== rtl/audio_sample_fifo_dither_pwm_unit.sv =====
// Audio sample FIFO with triangular dither feeding a 12-bit PWM level. Each
// request is a push of one signed 16-bit sample or a sample-rate tick, and
// each gives exactly one result. A push is stored in the ring RAM, or
// dropped when the FIFO is full, in which case the rest of that batch (up to
// batch_last) is dropped as well. A tick first pops the RAM (registered
// read) and advances the 32-bit dither LCG by two steps; then, once the output
// register is free, it adds the triangular dither, scales by 1/16 and
// clamps to 0..4095. An empty FIFO on a tick gives underrun with sample zero.
// room reports free entries after the request, low 12 bits. Results sit in
// an output register, so a new request is taken while the last result is
// still waiting, as long as that result leaves the register in the same
// cycle or it is empty. No clearing pass after reset: the RAM is read only
// at entries already written.
module audio_sample_fifo_dither_pwm_unit import asfdp_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	asfdp_in_if.sink    in_ch,
	asfdp_out_if.source out_ch
);
	asfdp_cmd_t  cmd;
	asfdp_stat_t stat;

	// sequencing: idle / tick finish
	asfdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.kind     (in_ch.kind),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// FIFO, dither generator, level math and output register
	asfdp_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.sample      (in_ch.sample),
		.batch_last  (in_ch.batch_last),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.level       (out_ch.level),
		.level_valid (out_ch.level_valid),
		.underrun    (out_ch.underrun),
		.accepted    (out_ch.accepted),
		.room        (out_ch.room)
	);
endmodule

// ===== rtl/asfdp_ram.sv =====
module asfdp_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/asfdp_ctrl.sv =====
module asfdp_ctrl import asfdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        kind,
	output logic        in_ready,
	input  asfdp_stat_t stat,
	output asfdp_cmd_t  cmd
);
	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_FINISH = 2'b10
	} asfdp_state_t;

	asfdp_state_t state_q, state_d;
	logic         take;

	assign in_ready   = (state_q == ST_IDLE) && stat.out_free;
	assign take       = in_valid && in_ready;
	assign cmd.push   = take && (kind == KIND_PUSH);
	assign cmd.tick   = take && (kind == KIND_TICK);
	assign cmd.finish = (state_q == ST_FINISH) && stat.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.tick) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/asfdp_dp.sv =====
module asfdp_dp import asfdp_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  asfdp_cmd_t          cmd,
	output asfdp_stat_t         stat,
	input  logic signed [15:0]  sample,
	input  logic                batch_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [11:0]         level,
	output logic                level_valid,
	output logic                underrun,
	output logic                accepted,
	output logic [11:0]         room
);
	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FILL_MAX = CW'(FIFO_DEPTH);

	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       fill_q, fill_d;
	logic                drop_q;
	logic [31:0]         seed_q, seed1, seed2;
	logic [DITHER_W:0]   dsum_q;
	logic                under_q;
	logic                empty, full, store, pop;
	logic [SAMPLE_W-1:0] rdata, smp;
	logic [16:0]         sum, sum_adj;
	logic [12:0]         lvl_raw;
	logic [11:0]         lvl;
	logic [31:0]         room_w;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == FILL_MAX);
	assign store = cmd.push && !drop_q && !full;
	assign pop   = cmd.tick && !empty;
	assign stat.out_free = !out_valid || out_ready;

	asfdp_ram #(.WIDTH(SAMPLE_W), .DEPTH(FIFO_DEPTH)) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (wr_ptr_q),
		.wdata (sample),
		.re    (pop),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_comb begin
		fill_d = fill_q;
		if (store) fill_d = fill_q + CW'(1);
		else if (pop) fill_d = fill_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			drop_q   <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (store) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (cmd.push) begin
				if (drop_q) begin
					if (batch_last) drop_q <= 1'b0;
				end else if (full && !batch_last) begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	// two LCG draws per tick, both from the current seed
	assign seed1 = seed_q * LCG_MUL + LCG_ADD;
	assign seed2 = seed_q * LCG_MUL2 + LCG_ADD2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd1;
		end else if (cmd.tick) begin
			seed_q <= seed2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			dsum_q  <= (DITHER_W + 1)'(seed1[DITHER_LSB +: DITHER_W])
				+ (DITHER_W + 1)'(seed2[DITHER_LSB +: DITHER_W]);
			under_q <= empty;
		end
	end

	// offset binary, add dither, drop bias, scale and clamp
	assign smp     = under_q ? '0 : rdata;
	assign sum     = 17'({~smp[15], smp[14:0]}) + 17'(dsum_q);
	assign sum_adj = sum - LEVEL_BIAS;
	assign lvl_raw = sum_adj[16:4];
	always_comb begin
		priority if (sum < LEVEL_BIAS) lvl = '0;
		else if (lvl_raw >= LEVEL_CAP) lvl = '1;
		else lvl = lvl_raw[11:0];
	end

	assign room_w = 32'(FIFO_DEPTH) - 32'(fill_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push || cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			level       <= '0;
			level_valid <= 1'b0;
			underrun    <= 1'b0;
			accepted    <= store;
			room        <= room_w[ROOM_W-1:0];
		end else if (cmd.finish) begin
			level       <= lvl;
			level_valid <= 1'b1;
			underrun    <= under_q;
			accepted    <= 1'b0;
			room        <= room_w[ROOM_W-1:0];
		end
	end
endmodule

// ===== rtl/asfdp_chk.sv =====
`include "audio_sample_fifo_dither_pwm_unit_macros.svh"

module asfdp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] level,
	input logic        level_valid,
	input logic        underrun,
	input logic        accepted
);
	`ASFDP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ASFDP_ASSERT_NOW(a_kind_excl, clk, arst_n, out_valid, !(level_valid && accepted), "tick result flagged accepted")
	`ASFDP_ASSERT_NOW(a_under_tick, clk, arst_n, out_valid && underrun, level_valid, "underrun on a push result")
	`ASFDP_ASSERT_NOW(a_push_zero, clk, arst_n, out_valid && !level_valid, level == 12'd0 && !underrun, "push result carries a level")
endmodule

bind audio_sample_fifo_dither_pwm_unit asfdp_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.level       (out_ch.level),
	.level_valid (out_ch.level_valid),
	.underrun    (out_ch.underrun),
	.accepted    (out_ch.accepted)
);

// ===== bench/audio_sample_fifo_dither_pwm_unit_tb.sv =====
module audio_sample_fifo_dither_pwm_unit_tb;
	import asfdp_pkg::*;

	localparam int unsigned RING_DEPTH     = 2048;
	localparam int unsigned CLK_PERIOD     = 20;
	localparam int unsigned RESET_CYCLES   = 6;
	localparam int unsigned RANDOM_ITEMS   = 894;
	localparam int unsigned PRESSURE_HOLD  = 300;
	localparam int unsigned DRAIN_CYCLES   = 16;
	localparam int unsigned MAX_REPORTS    = 100;
	// Worst case is about a thousand requests, each with the longest gap on both sides,
	// plus the pressure hold; this is several times that.
	localparam int unsigned TIMEOUT_CYCLES = 300_000;

	// Dither generator: 32-bit LCG, 5 bits taken from bit 20 up.
	localparam logic [31:0] DITHER_MUL  = 32'd1103515245;
	localparam logic [31:0] DITHER_INC  = 32'd12345;
	localparam int unsigned DITHER_SHR  = 20;
	localparam logic [16:0] LEVEL_FLOOR = 17'd31;
	localparam logic [12:0] LEVEL_TOP   = 13'd4095;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] sample;
		logic               batch_last;
	} pcm_request_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               level_valid;
		logic               underrun;
		logic               accepted;
		logic [ROOM_W-1:0]  room;
	} pwm_result_t;

	logic clk = 1'b0;
	logic arst_n;

	asfdp_in_if  in_ch();
	asfdp_out_if out_ch();

	audio_sample_fifo_dither_pwm_unit #(
		.FIFO_DEPTH(RING_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the block's state, advanced once per accepted request.
	// ------------------------------------------------------------------
	logic [15:0] ring_mem [RING_DEPTH];
	int unsigned wr_idx      = 0;
	int unsigned rd_idx      = 0;
	int unsigned ring_fill   = 0;
	logic [31:0] dither_lcg  = 32'd1;
	logic        drop_batch  = 1'b0;

	pwm_result_t awaited_pwm [$];
	int unsigned mismatch_cnt = 0;

	// Idling controls for the sender and the receiver.
	bit          tx_jitter   = 1'b0;
	bit          rx_jitter   = 1'b0;
	int unsigned hold_cycles = 0;

	function automatic logic [4:0] draw_dither();
		dither_lcg = dither_lcg * DITHER_MUL + DITHER_INC;
		return dither_lcg[DITHER_SHR +: 5];
	endfunction

	// Expected result of one request; updates the shadow state.
	function automatic pwm_result_t predict_pwm_result(pcm_request_t rq);
		pwm_result_t res;
		logic [15:0] popped;
		logic [4:0]  d1;
		logic [4:0]  d2;
		logic [16:0] biased;
		logic [12:0] scaled;

		res = '0;
		if (rq.kind == KIND_PUSH) begin
			if (drop_batch) begin
				// Rest of an overflowed batch: dropped even if room came back.
				if (rq.batch_last)
					drop_batch = 1'b0;
			end else if (ring_fill >= RING_DEPTH) begin
				if (!rq.batch_last)
					drop_batch = 1'b1;
			end else begin
				ring_mem[wr_idx] = rq.sample;
				wr_idx = (wr_idx + 1 >= RING_DEPTH) ? 0 : wr_idx + 1;
				ring_fill++;
				res.accepted = 1'b1;
			end
		end else begin
			popped = '0;
			if (ring_fill == 0) begin
				res.underrun = 1'b1;
			end else begin
				popped = ring_mem[rd_idx];
				rd_idx = (rd_idx + 1 >= RING_DEPTH) ? 0 : rd_idx + 1;
				ring_fill--;
			end
			d1 = draw_dither();
			d2 = draw_dither();
			// Offset binary plus triangular dither, then /16 with clamps at both ends.
			biased = 17'(popped ^ 16'h8000) + 17'(d1) + 17'(d2);
			if (biased < LEVEL_FLOOR) begin
				res.level = '0;
			end else begin
				scaled = 13'((biased - LEVEL_FLOOR) >> 4);
				res.level = (scaled > LEVEL_TOP) ? LEVEL_W'(LEVEL_TOP) : scaled[LEVEL_W-1:0];
			end
			res.level_valid = 1'b1;
		end
		res.room = ROOM_W'(RING_DEPTH - ring_fill);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Random audio word, leaning toward full-scale values now and then.
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Sender: one request, held until taken, then maybe a gap.
	// ------------------------------------------------------------------
	task automatic send_request(input logic kind, input logic signed [15:0] smp,
		input logic last);
		pcm_request_t rq;
		int unsigned  gap;

		rq = '{kind: kind, sample: smp, batch_last: last};
		@(negedge clk);
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= kind;
		in_ch.sample     <= smp;
		in_ch.batch_last <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		awaited_pwm.push_back(predict_pwm_result(rq));
		if (tx_jitter && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random back-pressure, plus one long hold on request.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned hold;

		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				hold = hold_cycles;
				hold_cycles = 0;
				out_ch.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
				hold = pick_gap();
				out_ch.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input int got, input int exp);
		if (got != exp)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp));
	endtask

	// Every result that leaves the block is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		pwm_result_t exp;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_pwm.size() == 0) begin
				report_mismatch($sformatf("result with nothing awaited (level %0d, room %0d)",
					out_ch.level, out_ch.room));
			end else begin
				exp = awaited_pwm.pop_front();
				check_field("level",       int'(out_ch.level),       int'(exp.level));
				check_field("level_valid", int'(out_ch.level_valid), int'(exp.level_valid));
				check_field("underrun",    int'(out_ch.underrun),    int'(exp.underrun));
				check_field("accepted",    int'(out_ch.accepted),    int'(exp.accepted));
				check_field("room",        int'(out_ch.room),        int'(exp.room));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Ticks right after reset: empty FIFO, zero sample, dither still runs.
	task automatic test_underrun_after_reset();
		repeat (3)
			send_request(KIND_TICK, 16'sh0000, 1'b0);
	endtask

	// Full-scale samples on both rails so dither pushes them past the clamps,
	// plus small values and alternating bit patterns.
	task automatic test_sample_extremes();
		logic signed [15:0] vals [10];

		vals = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
			-16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555};
		foreach (vals[i])
			send_request(KIND_PUSH, vals[i], (i == 4 || i == 9));
		send_request(KIND_PUSH, 16'shAAAA, 1'b1);
		repeat (12)
			send_request(KIND_TICK, 16'shFFFF, 1'b1);
	endtask

	// Receiver goes away for a long while; the sender keeps offering until
	// the block stops taking requests.
	task automatic test_output_stall();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		hold_cycles = PRESSURE_HOLD;
		repeat (30) begin
			if ($urandom_range(0, 1) == 0)
				send_request(KIND_PUSH, pick_sample(), 1'($urandom_range(0, 1)));
			else
				send_request(KIND_TICK, pick_sample(), 1'($urandom_range(0, 1)));
		end
	endtask

	// Batches of pushes interleaved with ticks; push rate and idling change
	// every so often so the fill level wanders and empty ticks occur.
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned push_pct;
		int unsigned batch_left;

		push_pct = 50;
		batch_left = 0;
		for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
			if (sent % 64 == 0) begin
				tx_jitter = $urandom_range(0, 2) != 0;
				rx_jitter = $urandom_range(0, 2) != 0;
				push_pct = $urandom_range(25, 75);
			end
			if (batch_left == 0)
				batch_left = $urandom_range(1, 8);
			if ($urandom_range(0, 99) < push_pct) begin
				batch_left--;
				send_request(KIND_PUSH, pick_sample(),
					(batch_left == 0) || ($urandom_range(0, 15) == 0));
			end else begin
				// Tick payload is don't-care; random to exercise the input bits.
				send_request(KIND_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin : main
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_PUSH;
		in_ch.sample = '0;
		in_ch.batch_last = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_underrun_after_reset();
		test_sample_extremes();
		test_output_stall();
		test_random_traffic();

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (awaited_pwm.size() != 0)
			@(posedge clk);
		// Give a stray extra result time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Verification failed");
		$finish;
	end

endmodule
